// ----- hw/rtl/scaled_dot_product_attention_2x2_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the attention block
// ----------------------------------------------------------------------------
`ifndef SCALED_DOT_PRODUCT_ATTENTION_2X2_MACROS_SVH
`define SCALED_DOT_PRODUCT_ATTENTION_2X2_MACROS_SVH

// same-cycle implication, disabled during reset
`define SDPA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled during reset
`define SDPA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- hw/rtl/sdpa_pkg.sv -----
// ----------------------------------------------------------------------------
// sdpa_pkg
// types, constants and helpers of the 2x2 attention block
// ----------------------------------------------------------------------------
package sdpa_pkg;

	localparam int FRAC_BITS = 12;

	localparam logic [16:0] W_ONE         = 17'h10000;
	localparam logic [15:0] INV_SQRT2_Q16 = 16'd46341;
	localparam logic [16:0] LOG2E_Q16     = 17'd94548;
	localparam logic [15:0] LN2_Q16       = 16'd45426;
	localparam int          EXP_TERMS     = 6;

	// width of the scaled score gap after rounding
	localparam int T_W = 49 - 2 * FRAC_BITS;

	// quotient bits of the reciprocal divider
	localparam int DIV_BITS = 17;

	// lane: products, sums, scale, log2e, ln2, two stages per exp term, den, divider, weight
	localparam int LANE_LAT = 5 + 2 * EXP_TERMS + 1 + DIV_BITS + 1;
	// lane plus two mixing stages
	localparam int PIPE_LAT = LANE_LAT + 2;

	typedef struct packed {
		logic signed [15:0] q_r0c0;
		logic signed [15:0] q_r0c1;
		logic signed [15:0] q_r1c0;
		logic signed [15:0] q_r1c1;
		logic signed [15:0] k_r0c0;
		logic signed [15:0] k_r0c1;
		logic signed [15:0] k_r1c0;
		logic signed [15:0] k_r1c1;
		logic signed [15:0] v_r0c0;
		logic signed [15:0] v_r0c1;
		logic signed [15:0] v_r1c0;
		logic signed [15:0] v_r1c1;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] out_r0c0;
		logic signed [15:0] out_r0c1;
		logic signed [15:0] out_r1c0;
		logic signed [15:0] out_r1c1;
	} out_item_t;

	typedef struct packed {
		logic signed [15:0] r0c0;
		logic signed [15:0] r0c1;
		logic signed [15:0] r1c0;
		logic signed [15:0] r1c1;
	} vmat_t;

	// truncating divide of a 16-bit value by a small constant, by reciprocal multiply
	function automatic logic [15:0] div_small(input logic [15:0] p, input int k);
		logic [33:0] pr;
		logic [15:0] r;
		pr = '0;
		case (k)
			1: r = p;
			2: r = p >> 1;
			3: begin
				pr = 34'(p) * 34'(43691);
				r  = 16'(pr >> 17);
			end
			4: r = p >> 2;
			5: begin
				pr = 34'(p) * 34'(52429);
				r  = 16'(pr >> 18);
			end
			6: begin
				pr = 34'(p) * 34'(43691);
				r  = 16'(pr >> 18);
			end
			default: r = p;
		endcase
		return r;
	endfunction

endpackage

// ----- hw/rtl/sdpa_if.sv -----
// ----------------------------------------------------------------------------
// sdpa stream interfaces
// valid/ready channels for the input matrices and the attention result
// ----------------------------------------------------------------------------
interface sdpa_in_if;
	logic               valid;
	logic               ready;
	sdpa_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sdpa_out_if;
	logic                valid;
	logic                ready;
	sdpa_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/sdpa_lane.sv -----
// ----------------------------------------------------------------------------
// sdpa_lane
// one query row: scores, scaled gap, exp approximation and softmax weight
// ----------------------------------------------------------------------------
module sdpa_lane (
	input  logic               clk,
	input  logic               en,
	input  logic signed [15:0] q0,
	input  logic signed [15:0] q1,
	input  logic signed [15:0] k00,
	input  logic signed [15:0] k01,
	input  logic signed [15:0] k10,
	input  logic signed [15:0] k11,
	output logic [16:0]        w0
);

	localparam int TW  = sdpa_pkg::T_W;
	localparam int NT  = sdpa_pkg::EXP_TERMS;
	localparam int DB  = sdpa_pkg::DIV_BITS;
	localparam int GEL = 3 + 2 * NT + 1 + DB;

	logic signed [31:0] p00_s1, p01_s1, p10_s1, p11_s1;
	logic [32:0]        mag_s2;
	logic               ge_s2;
	logic [TW-1:0]      t_s3;
	logic               big_s4;
	logic [4:0]         sh_s4;
	logic [15:0]        f_s4;
	logic [15:0]        u_s5;

	logic               ge_q [GEL];
	logic [5:0]         bs_q [2 * NT + 1];

	logic signed [32:0] sc0, sc1;
	logic signed [33:0] dif;
	logic [48:0]        m;
	logic [TW+16:0]     zp, zs;

	always_comb begin
		sc0 = 33'(p00_s1) + 33'(p01_s1);
		sc1 = 33'(p10_s1) + 33'(p11_s1);
		dif = 34'(sc0) - 34'(sc1);
		m   = 49'(mag_s2) * 49'(sdpa_pkg::INV_SQRT2_Q16);
		zp  = (TW+17)'(t_s3) * (TW+17)'(sdpa_pkg::LOG2E_Q16);
		zs  = zp + (TW+17)'(32768);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1 <= q0 * k00;
			p01_s1 <= q1 * k01;
			p10_s1 <= q0 * k10;
			p11_s1 <= q1 * k11;
			mag_s2 <= dif[33] ? 33'(-dif) : 33'(dif);
			ge_s2  <= !dif[33];
			t_s3   <= TW'((m + (49'(1) << (2 * sdpa_pkg::FRAC_BITS - 1)))
				>> (2 * sdpa_pkg::FRAC_BITS));
			big_s4 <= zs[TW+16:32] >= (TW-15)'(17);
			sh_s4  <= zs[36:32];
			f_s4   <= zs[31:16];
			u_s5   <= 16'((32'(f_s4) * 32'(sdpa_pkg::LN2_Q16) + 32'd32768) >> 16);
			ge_q[0] <= ge_s2;
			for (int i = 1; i < GEL; i++) ge_q[i] <= ge_q[i-1];
			bs_q[0] <= {big_s4, sh_s4};
			for (int i = 1; i < 2 * NT + 1; i++) bs_q[i] <= bs_q[i-1];
		end
	end

	// horner evaluation of e^-u, two stages per term
	logic [15:0] hua_q [NT];
	logic [15:0] hub_q [NT];
	logic [15:0] hp_q  [NT];
	logic [16:0] ha_q  [NT];

	genvar j;
	generate
		for (j = 0; j < NT; j++) begin : g_term
			logic [15:0] u_in;
			logic [16:0] a_in;
			if (j == 0) begin : g_first
				assign u_in = u_s5;
				assign a_in = sdpa_pkg::W_ONE;
			end else begin : g_next
				assign u_in = hub_q[j-1];
				assign a_in = ha_q[j-1];
			end
			always_ff @(posedge clk) begin
				if (en) begin
					hp_q[j]  <= 16'((33'(u_in) * 33'(a_in)) >> 16);
					hua_q[j] <= u_in;
					ha_q[j]  <= sdpa_pkg::W_ONE - 17'(sdpa_pkg::div_small(hp_q[j], NT - j));
					hub_q[j] <= hua_q[j];
				end
			end
		end
	endgenerate

	// denominator 1 + e
	logic [17:0] den_q;
	logic [16:0] e_v;
	logic        big_v;
	logic [4:0]  sh_v;

	always_comb begin
		{big_v, sh_v} = bs_q[2 * NT];
		e_v = big_v ? 17'd0 : (ha_q[NT-1] >> sh_v);
	end

	always_ff @(posedge clk) begin
		if (en) den_q <= 18'(sdpa_pkg::W_ONE) + 18'(e_v);
	end

	// restoring divider for round(2^32 / den), one quotient bit a stage
	logic [17:0]   rem_q [DB];
	logic [16:0]   lo_q  [DB];
	logic [17:0]   dv_q  [DB];
	logic [DB-1:0] qt_q  [DB];

	genvar b;
	generate
		for (b = 0; b < DB; b++) begin : g_div
			logic [17:0]   rem_in, dv_in;
			logic [16:0]   lo_in;
			logic [DB-1:0] qt_in;
			logic [18:0]   r1;
			if (b == 0) begin : g_first
				assign rem_in = 18'd32768;
				assign lo_in  = den_q[17:1];
				assign dv_in  = den_q;
				assign qt_in  = '0;
			end else begin : g_next
				assign rem_in = rem_q[b-1];
				assign lo_in  = lo_q[b-1];
				assign dv_in  = dv_q[b-1];
				assign qt_in  = qt_q[b-1];
			end
			assign r1 = {rem_in, lo_in[DB-1-b]};
			always_ff @(posedge clk) begin
				if (en) begin
					if (r1 >= {1'b0, dv_in}) begin
						rem_q[b] <= 18'(r1 - {1'b0, dv_in});
						qt_q[b]  <= {qt_in[DB-2:0], 1'b1};
					end else begin
						rem_q[b] <= r1[17:0];
						qt_q[b]  <= {qt_in[DB-2:0], 1'b0};
					end
					lo_q[b] <= lo_in;
					dv_q[b] <= dv_in;
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) w0 <= ge_q[GEL-1] ? qt_q[DB-1] : sdpa_pkg::W_ONE - qt_q[DB-1];
	end

endmodule

// ----- hw/rtl/sdpa_mix.sv -----
// ----------------------------------------------------------------------------
// sdpa_mix
// merges the lane weights with the value rows into the rounded result
// ----------------------------------------------------------------------------
module sdpa_mix (
	input  logic                clk,
	input  logic                en,
	input  logic [16:0]         w0_r0,
	input  logic [16:0]         w0_r1,
	input  sdpa_pkg::vmat_t     v,
	output sdpa_pkg::out_item_t res
);

	logic signed [34:0] m00_s1, m01_s1, m10_s1, m11_s1;
	logic signed [15:0] b0_s1, b1_s1;

	// w0*v0 + (1-w0)*v1 = w0*(v0-v1) + v1
	function automatic logic signed [34:0] wmul(input logic [16:0] w,
		input logic signed [15:0] a, input logic signed [15:0] c);
		logic signed [16:0] d;
		d = 17'(a) - 17'(c);
		return 35'(signed'({1'b0, w}) * d);
	endfunction

	function automatic logic signed [15:0] rnd(input logic signed [34:0] p,
		input logic signed [15:0] base);
		logic signed [36:0] acc;
		acc = 37'(p) + (37'(base) <<< 16) + 37'sd32768;
		return 16'(acc >>> 16);
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			m00_s1 <= wmul(w0_r0, v.r0c0, v.r1c0);
			m01_s1 <= wmul(w0_r0, v.r0c1, v.r1c1);
			m10_s1 <= wmul(w0_r1, v.r0c0, v.r1c0);
			m11_s1 <= wmul(w0_r1, v.r0c1, v.r1c1);
			b0_s1  <= v.r1c0;
			b1_s1  <= v.r1c1;
			res.out_r0c0 <= rnd(m00_s1, b0_s1);
			res.out_r0c1 <= rnd(m01_s1, b1_s1);
			res.out_r1c0 <= rnd(m10_s1, b0_s1);
			res.out_r1c1 <= rnd(m11_s1, b1_s1);
		end
	end

endmodule

// ----- hw/rtl/scaled_dot_product_attention_2x2.sv -----
// ----------------------------------------------------------------------------
// scaled_dot_product_attention_2x2
// 2x2 scaled dot-product attention, signed Q4.12 in and out
// ----------------------------------------------------------------------------
// Takes one request per cycle (Q, K and V, each 2x2 in Q4.12) while the output
// side does not stall and returns one 2x2 result in Q4.12 for each, in order.
// Two lanes, one per query row, work side by side: each forms its two scores,
// scales the gap by 1/sqrt(2), runs a six-term exp approximation (two stages a
// term) and a 17-stage bit-serial divider that gives the softmax weight. Most of
// the pipeline depth lies in that divider and the exp pipeline. The mixer then
// blends the value rows under each row's weight with half-up rounding. The whole
// pipeline advances together; it only holds when a result sits at the output and
// is not taken, so a stall on the result side stops new requests at once. No
// state is kept between requests.
// ----------------------------------------------------------------------------
`include "scaled_dot_product_attention_2x2_macros.svh"

module scaled_dot_product_attention_2x2 (
	input logic        clk,
	input logic        arst_n,
	sdpa_in_if.sink    qkv,
	sdpa_out_if.source att
);

	localparam int LL = sdpa_pkg::LANE_LAT;
	localparam int PL = sdpa_pkg::PIPE_LAT;

	// valid bit for every pipeline slot, last one is the output register
	logic [PL-1:0]   vld_q;
	logic            en;
	logic [16:0]     w0_r0, w0_r1;
	sdpa_pkg::vmat_t vd_q [LL];
	sdpa_pkg::vmat_t v_in;

	// advance unless a finished result is held back
	assign en        = !vld_q[PL-1] || att.ready;
	assign qkv.ready = en;
	assign att.valid = vld_q[PL-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PL-2:0], qkv.valid};
		end
	end

	// value matrix travels alongside the lanes
	assign v_in = '{qkv.data.v_r0c0, qkv.data.v_r0c1, qkv.data.v_r1c0, qkv.data.v_r1c1};

	always_ff @(posedge clk) begin
		if (en) begin
			vd_q[0] <= v_in;
			for (int i = 1; i < LL; i++) vd_q[i] <= vd_q[i-1];
		end
	end

	// row 0 lane
	sdpa_lane u_lane0 (
		.clk (clk),
		.en  (en),
		.q0  (qkv.data.q_r0c0),
		.q1  (qkv.data.q_r0c1),
		.k00 (qkv.data.k_r0c0),
		.k01 (qkv.data.k_r0c1),
		.k10 (qkv.data.k_r1c0),
		.k11 (qkv.data.k_r1c1),
		.w0  (w0_r0)
	);

	// row 1 lane
	sdpa_lane u_lane1 (
		.clk (clk),
		.en  (en),
		.q0  (qkv.data.q_r1c0),
		.q1  (qkv.data.q_r1c1),
		.k00 (qkv.data.k_r0c0),
		.k01 (qkv.data.k_r0c1),
		.k10 (qkv.data.k_r1c0),
		.k11 (qkv.data.k_r1c1),
		.w0  (w0_r1)
	);

	// merge weights with values, output register inside
	sdpa_mix u_mix (
		.clk   (clk),
		.en    (en),
		.w0_r0 (w0_r0),
		.w0_r1 (w0_r1),
		.v     (vd_q[LL-1]),
		.res   (att.data)
	);

	// a held result freezes every slot of the pipeline
	`SDPA_ASSERT_NXT(a_hold_pipe, clk, arst_n, att.valid && !att.ready, $stable(vld_q))
	// requests are refused only while a result waits
	`SDPA_ASSERT_IMP(a_ready_why, clk, arst_n, !qkv.ready, att.valid)
	// softmax weights never exceed one
	`SDPA_ASSERT_IMP(a_w_range, clk, arst_n, vld_q[LL-1],
		(w0_r0 <= sdpa_pkg::W_ONE) && (w0_r1 <= sdpa_pkg::W_ONE))

endmodule
